// ----- hw/rtl/tsc_pkg.sv -----
// tsc_pkg: types and codes shared by the tile scissor clipper modules.
// No dependencies.
package tsc_pkg;

  localparam int unsigned CoordW = 32;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_POP   = 2'd2,
    KIND_RESET = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_EMIT      = 3'd0,
    ST_CULL      = 3'd1,
    ST_CLIP_DONE = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [31:0] l;
    logic signed [31:0] t;
    logic signed [31:0] r;
    logic signed [31:0] b;
  } box_t;

  // A draw item classified by the front: clipped destination, raw source,
  // which edges moved and their shifts.
  typedef struct packed {
    logic               cull;
    box_t               dst;
    box_t               src;
    logic [3:0]         clip;   // l, r, t, b order in bits 0..3
    logic signed [32:0] sh_l;
    logic signed [32:0] sh_r;
    logic signed [32:0] sh_t;
    logic signed [32:0] sh_b;
    logic [32:0]        dw;
    logic [32:0]        dh;
    logic [15:0]        texture;
    logic [23:0]        tint;
    logic [31:0]        flags;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_DIV  = 2'd2,
    BK_DONE = 2'd3
  } bk_state_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        w;
    logic [30:0]        h;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sw;
    logic signed [31:0] sh;
    logic [15:0]        texture;
    logic [23:0]        tint;
    logic [31:0]        flags;
  } result_t;

endpackage

// ----- hw/rtl/tile_scissor_clipper.sv -----
// tile_scissor_clipper: top level, joins front and back of the clipper.
// Depends on tsc_pkg, tsc_front, tsc_back.
//
// Usage: commands enter on the in_ stream, one item per command; each gives
// one result item on the out_ stream, in order. in_tuser carries the kind
// (draw, push, pop, reset); in_tdata carries the rectangles and pass-through
// words. out_tuser carries the status.
// Path: push, pop, reset and unclipped or culled draws pass the front's
// output register and then the back's result register. A draw that crosses the
// clip box runs a multiply and a 64-step divide for each moved edge in the
// shared back-end divider.
// Flow: the front takes no new item while its output register is full or a
// pop read waits; clipped draws are divider-bound. A one-entry queue between
// front and back lets the front take one more item while the back works.
// Reset (rst_n low, synchronous) empties the stack and loads the full
// coordinate range as clip box. When out_tready is low the result holds and
// the block backs up into in_tready.
module tile_scissor_clipper #(
  parameter int unsigned CLIP_STACK_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // rect l,t,r,b, src l,t,r,b, texture_id, tint_rgb, draw_flags
  input  logic [327:0] in_tdata,
  // kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_width, out_height, out_src_x, out_src_y,
  // out_src_width, out_src_height, out_texture, out_tint, out_flags, pad
  output logic [327:0] out_tdata,
  // status
  output logic [2:0]   out_tuser
);
  tsc_pkg::box_t    rect, src;
  logic             q_valid, q_ready, q_is_draw;
  logic [2:0]       q_status;
  tsc_pkg::job_t    q_job;
  tsc_pkg::result_t res;

  assign rect = '{l: in_tdata[31:0], t: in_tdata[63:32],
                  r: in_tdata[95:64], b: in_tdata[127:96]};
  assign src  = '{l: in_tdata[159:128], t: in_tdata[191:160],
                  r: in_tdata[223:192], b: in_tdata[255:224]};

  tsc_front #(.CLIP_STACK_DEPTH(CLIP_STACK_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .kind(in_tuser), .rect(rect), .src(src), .texture(in_tdata[271:256]),
    .tint(in_tdata[295:272]), .flags(in_tdata[327:296]),
    .q_valid(q_valid), .q_ready(q_ready), .q_is_draw(q_is_draw),
    .q_status(q_status), .q_job(q_job)
  );

  tsc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_is_draw(q_is_draw), .q_status(q_status), .q_job(q_job),
    .r_valid(out_tvalid), .r_ready(out_tready), .r_data(res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {2'b00, res.flags, res.tint, res.texture, res.sh, res.sw,
                      res.sy, res.sx, res.h, res.w, res.y, res.x};
endmodule

// ----- hw/rtl/tsc_front.sv -----
// tsc_front: accepts items, runs the clip box stack and classifies draws.
// Depends on tsc_pkg.
module tsc_front #(
  parameter int unsigned CLIP_STACK_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  tsc_pkg::box_t        rect,
  input  tsc_pkg::box_t        src,
  input  logic [15:0]          texture,
  input  logic [23:0]          tint,
  input  logic [31:0]          flags,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic                 q_is_draw,
  output logic [2:0]           q_status,
  output tsc_pkg::job_t        q_job
);
  localparam int unsigned AW = (CLIP_STACK_DEPTH > 1) ? $clog2(CLIP_STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(CLIP_STACK_DEPTH + 1);

  tsc_pkg::box_t box_r, box_nxt;
  tsc_pkg::box_t mem [CLIP_STACK_DEPTH];
  tsc_pkg::box_t rd_r;
  logic [LW-1:0] lvl_r, lvl_nxt;
  // pop waits for the registered memory read in rd_r
  logic          pop_pend_r;
  logic          ov_valid_r;
  logic          ov_draw_r;
  logic [2:0]    ov_status_r;
  tsc_pkg::job_t ov_job_r;
  logic          acc;
  logic          full, empty;
  logic [LW-1:0] lvl_m1;
  tsc_pkg::box_t pb;
  tsc_pkg::job_t jb;
  logic signed [32:0] dl, dt, dr, db;
  logic [2:0]    st;

  assign in_ready = !ov_valid_r && !pop_pend_r;
  assign acc = in_valid && in_ready;
  assign full = (lvl_r == LW'(CLIP_STACK_DEPTH));
  assign empty = (lvl_r == '0);
  assign lvl_m1 = lvl_r - LW'(1);

  always_comb begin
    pb.l = (rect.l > box_r.l) ? rect.l : box_r.l;
    pb.t = (rect.t > box_r.t) ? rect.t : box_r.t;
    pb.r = (rect.r < box_r.r) ? rect.r : box_r.r;
    pb.b = (rect.b < box_r.b) ? rect.b : box_r.b;
    if (pb.r < pb.l) pb.r = pb.l;
    if (pb.b < pb.t) pb.b = pb.t;
  end

  always_comb begin
    dl = 33'(rect.l); dt = 33'(rect.t); dr = 33'(rect.r); db = 33'(rect.b);
    jb = '0;
    jb.src = src;
    jb.texture = texture; jb.tint = tint; jb.flags = flags;
    jb.dw = 33'(dr - dl);
    jb.dh = 33'(db - dt);
    jb.clip[0] = rect.l < box_r.l;
    jb.clip[1] = rect.r > box_r.r;
    jb.clip[2] = rect.t < box_r.t;
    jb.clip[3] = rect.b > box_r.b;
    jb.sh_l = 33'(box_r.l) - dl;
    jb.sh_r = 33'(box_r.r) - dr;
    jb.sh_t = 33'(box_r.t) - dt;
    jb.sh_b = 33'(box_r.b) - db;
    jb.dst.l = jb.clip[0] ? box_r.l : rect.l;
    jb.dst.r = jb.clip[1] ? box_r.r : rect.r;
    jb.dst.t = jb.clip[2] ? box_r.t : rect.t;
    jb.dst.b = jb.clip[3] ? box_r.b : rect.b;
    jb.cull = (rect.l >= rect.r) || (rect.t >= rect.b) ||
              !(jb.dst.l < jb.dst.r && jb.dst.t < jb.dst.b);
  end

  always_comb begin
    box_nxt = box_r;
    lvl_nxt = lvl_r;
    st = tsc_pkg::ST_CLIP_DONE;
    if (pop_pend_r) begin
      box_nxt = rd_r;
    end else if (acc) begin
      case (tsc_pkg::kind_t'(kind))
        tsc_pkg::KIND_PUSH: begin
          if (full) st = tsc_pkg::ST_OVERFLOW;
          else begin
            box_nxt = pb;
            lvl_nxt = lvl_r + LW'(1);
          end
        end
        tsc_pkg::KIND_POP: begin
          if (empty) st = tsc_pkg::ST_UNDERFLOW;
          else lvl_nxt = lvl_m1;
        end
        tsc_pkg::KIND_RESET: begin
          box_nxt = rect;
          lvl_nxt = '0;
        end
        default: st = tsc_pkg::ST_EMIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc && tsc_pkg::kind_t'(kind) == tsc_pkg::KIND_PUSH && !full)
      mem[lvl_r[AW-1:0]] <= box_r;
    rd_r <= mem[lvl_m1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= '{l: 32'sh8000_0000, t: 32'sh8000_0000,
                 r: 32'sh7fff_ffff, b: 32'sh7fff_ffff};
      lvl_r <= '0;
      pop_pend_r <= 1'b0;
      ov_valid_r <= 1'b0;
    end else begin
      box_r <= box_nxt;
      lvl_r <= lvl_nxt;
      pop_pend_r <= acc && tsc_pkg::kind_t'(kind) == tsc_pkg::KIND_POP && !empty;
      if (acc) ov_valid_r <= 1'b1;
      else if (q_ready) ov_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ov_draw_r <= (tsc_pkg::kind_t'(kind) == tsc_pkg::KIND_DRAW);
      ov_status_r <= st;
      ov_job_r <= jb;
    end
  end

  assign q_valid = ov_valid_r;
  assign q_is_draw = ov_draw_r;
  assign q_status = ov_status_r;
  assign q_job = ov_job_r;

  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LW'(CLIP_STACK_DEPTH)) else $error("stack level out of range");
  a_no_acc_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pop_pend_r |-> !acc) else $error("accept during pop read");
  a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
    pop_pend_r |=> !pop_pend_r) else $error("pop pending twice");
endmodule

// ----- hw/rtl/tsc_divider.sv -----
// tsc_divider: unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing.
module tsc_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [63:0] q_r;
  logic [33:0] rem_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [33:0] trial;
  logic [33:0] diff;

  assign trial = {rem_r[32:0], q_r[63]};
  assign diff = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 7'd64;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_r <= diff;
        q_r <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r <= {q_r[62:0], 1'b0};
      end
    end
  end

  assign done = busy_r && (cnt_r == 7'd1);
  assign quo = diff[33] ? {q_r[62:0], 1'b0} : {q_r[62:0], 1'b1};
endmodule

// ----- hw/rtl/tsc_back.sv -----
// tsc_back: shifts the source edges of clipped draws and forms results.
// Depends on tsc_pkg and tsc_divider.
module tsc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic             q_is_draw,
  input  logic [2:0]       q_status,
  input  tsc_pkg::job_t    q_job,
  output logic             r_valid,
  input  logic             r_ready,
  output tsc_pkg::result_t r_data
);
  tsc_pkg::bk_state_t st_r, st_nxt;
  tsc_pkg::job_t      job_r;
  logic [1:0]         edge_r;
  logic [63:0]        prod;
  logic               neg_r;
  logic signed [33:0] acc_r [4];
  logic               out_v_r;
  tsc_pkg::result_t   out_r;
  logic               take;
  logic               div_start, div_done;
  logic [63:0]        div_q;
  logic signed [32:0] ext, shf;
  logic [32:0]        me, ms, den;
  logic [33:0]        qc;
  logic signed [33:0] sv;
  logic signed [31:0] sl, st_, sr, sb;
  tsc_pkg::result_t   res;
  tsc_pkg::result_t   pass_res;

  function automatic logic signed [31:0] sat(input logic signed [34:0] v);
    if (v > 35'sh0_7fff_ffff) return 32'sh7fff_ffff;
    if (v < -35'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  assign take = q_valid && q_ready;
  assign q_ready = (st_r == tsc_pkg::BK_IDLE) && !out_v_r;

  always_comb begin
    case (edge_r)
      2'd0: begin ext = 33'(job_r.src.r) - 33'(job_r.src.l); shf = job_r.sh_l; end
      2'd1: begin ext = 33'(job_r.src.r) - 33'(job_r.src.l); shf = job_r.sh_r; end
      2'd2: begin ext = 33'(job_r.src.b) - 33'(job_r.src.t); shf = job_r.sh_t; end
      default: begin ext = 33'(job_r.src.b) - 33'(job_r.src.t); shf = job_r.sh_b; end
    endcase
    me = ext[32] ? 33'(-ext) : ext;
    ms = shf[32] ? 33'(-shf) : shf;
    den = edge_r[1] ? job_r.dh : job_r.dw;
    qc = (div_q > 64'd8589934592) ? 34'd8589934592 : div_q[33:0];
    sv = neg_r ? -$signed(qc) : $signed(qc);
  end

  // product goes straight into the divider on its start cycle
  assign prod = 64'(me) * 64'(ms);
  assign div_start = (st_r == tsc_pkg::BK_MUL);

  tsc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(prod), .den(den),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tsc_pkg::BK_IDLE:
        if (take && q_is_draw && !q_job.cull && q_job.clip != 4'd0)
          st_nxt = tsc_pkg::BK_MUL;
        else if (take) st_nxt = tsc_pkg::BK_IDLE;
      tsc_pkg::BK_MUL: st_nxt = tsc_pkg::BK_DIV;
      tsc_pkg::BK_DIV:
        if (div_done) st_nxt = tsc_pkg::BK_DONE;
      default: begin
        if (job_r.clip[3:0] >> (edge_r + 2'd1) == 4'd0 || edge_r == 2'd3)
          st_nxt = tsc_pkg::BK_IDLE;
        else st_nxt = tsc_pkg::BK_MUL;
      end
    endcase
  end

  always_comb begin
    sl  = sat(35'(acc_r[0]));
    sr  = sat(35'(acc_r[1]));
    st_ = sat(35'(acc_r[2]));
    sb  = sat(35'(acc_r[3]));
    res = '0;
    res.status = tsc_pkg::ST_EMIT;
    res.x = job_r.dst.l;
    res.y = job_r.dst.t;
    res.w = (35'(job_r.dst.r) - 35'(job_r.dst.l) > 35'sh0_7fff_ffff) ? 31'h7fff_ffff
            : 31'(33'(job_r.dst.r) - 33'(job_r.dst.l));
    res.h = (35'(job_r.dst.b) - 35'(job_r.dst.t) > 35'sh0_7fff_ffff) ? 31'h7fff_ffff
            : 31'(33'(job_r.dst.b) - 33'(job_r.dst.t));
    res.sx = sl;
    res.sy = st_;
    res.sw = sat(35'(sr) - 35'(sl));
    res.sh = sat(35'(sb) - 35'(st_));
    res.texture = job_r.texture;
    res.tint = job_r.tint;
    res.flags = job_r.flags;
  end

  // result of an item that needs no edge shift
  always_comb begin
    pass_res = '0;
    if (!q_is_draw) pass_res.status = q_status;
    else if (q_job.cull) pass_res.status = tsc_pkg::ST_CULL;
    else begin
      pass_res.status = tsc_pkg::ST_EMIT;
      pass_res.x = q_job.dst.l;
      pass_res.y = q_job.dst.t;
      pass_res.w = (q_job.dw > 33'h0_7fff_ffff) ? 31'h7fff_ffff : q_job.dw[30:0];
      pass_res.h = (q_job.dh > 33'h0_7fff_ffff) ? 31'h7fff_ffff : q_job.dh[30:0];
      pass_res.sx = q_job.src.l;
      pass_res.sy = q_job.src.t;
      pass_res.sw = sat(35'(q_job.src.r) - 35'(q_job.src.l));
      pass_res.sh = sat(35'(q_job.src.b) - 35'(q_job.src.t));
      pass_res.texture = q_job.texture;
      pass_res.tint = q_job.tint;
      pass_res.flags = q_job.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tsc_pkg::BK_IDLE;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_v_r && r_ready) out_v_r <= 1'b0;
      if (take && (!q_is_draw || q_job.cull || q_job.clip == 4'd0)) out_v_r <= 1'b1;
      if (st_r == tsc_pkg::BK_DONE && st_nxt == tsc_pkg::BK_IDLE) out_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= q_job;
      acc_r[0] <= 34'(q_job.src.l);
      acc_r[1] <= 34'(q_job.src.r);
      acc_r[2] <= 34'(q_job.src.t);
      acc_r[3] <= 34'(q_job.src.b);
      edge_r <= q_job.clip[0] ? 2'd0 : q_job.clip[1] ? 2'd1 : q_job.clip[2] ? 2'd2 : 2'd3;
      out_r <= pass_res;
    end else begin
      case (st_r)
        tsc_pkg::BK_MUL: begin
          neg_r <= ext[32] != shf[32];
        end
        tsc_pkg::BK_DIV:
          if (div_done) acc_r[edge_r] <= acc_r[edge_r] + sv;
        tsc_pkg::BK_DONE: begin
          if (st_nxt == tsc_pkg::BK_IDLE) out_r <= res;
          else if (job_r.clip[edge_r + 2'd1]) edge_r <= edge_r + 2'd1;
          else if (edge_r <= 2'd1 && job_r.clip[edge_r + 2'd2]) edge_r <= edge_r + 2'd2;
          else edge_r <= 2'd3;
        end
        default: ;
      endcase
    end
  end

  assign r_valid = out_v_r;
  assign r_data = out_r;

  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != tsc_pkg::BK_IDLE) |-> !q_ready) else $error("take while busy");
  a_mul_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == tsc_pkg::BK_MUL) |=> (st_r == tsc_pkg::BK_DIV)) else $error("mul step");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !r_ready |=> out_v_r) else $error("result dropped");
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for tile_scissor_clipper; directed and random commands.
// It predicts each result from the command stream and compares it field by field.
// Depends on tsc_pkg and tile_scissor_clipper.
module testbench;

  localparam int unsigned StackDepth = 16;
  localparam longint S32Min = -64'sd2147483648;
  localparam longint S32Max = 64'sd2147483647;
  localparam longint ShiftClamp = 64'sd8589934592;
  localparam int unsigned WatchLimit = 20000;

  typedef struct {
    tsc_pkg::kind_t     kind;
    logic signed [31:0] rl, rt, rr, rb;
    logic signed [31:0] sl, st, sr, sb;
    logic [15:0]        tex;
    logic [23:0]        tint;
    logic [31:0]        flags;
  } tile_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [327:0] in_tdata = '0;
  logic [1:0] in_tuser = tsc_pkg::KIND_DRAW;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [327:0] out_tdata;
  logic [2:0] out_tuser;

  tile_cmd_t        cmd_q[$];
  tsc_pkg::result_t clip_expect_q[$];
  tile_cmd_t        cur_cmd;
  int unsigned items_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Predictor state: current clip box and the saved-box stack.
  longint box_l, box_t_, box_r, box_b;
  longint sav_l[StackDepth], sav_t[StackDepth], sav_r[StackDepth], sav_b[StackDepth];
  int unsigned stack_lvl;

  always #4 clk = ~clk;

  tile_scissor_clipper #(.CLIP_STACK_DEPTH(StackDepth)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  function automatic longint sat32(longint v);
    if (v < S32Min) return S32Min;
    if (v > S32Max) return S32Max;
    return v;
  endfunction

  // trunc(ext * shift / dext); magnitudes below 2^32 so the product fits 64 bits
  function automatic longint edge_shift(longint ext, longint sh, longint dext);
    bit neg;
    bit [63:0] me, ms, q;
    neg = (ext < 0) != (sh < 0);
    me = (ext < 0) ? -ext : ext;
    ms = (sh < 0) ? -sh : sh;
    q = (me * ms) / 64'(dext);
    if (q > 64'(ShiftClamp)) q = 64'(ShiftClamp);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic tsc_pkg::result_t clip_predict(tile_cmd_t c);
    tsc_pkg::result_t r;
    longint dl, dt, dr, db, s_l, s_t, s_r, s_b, dw, dh, sw, sh;
    r = '0;
    dl = c.rl; dt = c.rt; dr = c.rr; db = c.rb;
    case (c.kind)
      tsc_pkg::KIND_PUSH: begin
        if (stack_lvl >= StackDepth) begin
          r.status = tsc_pkg::ST_OVERFLOW;
          return r;
        end
        sav_l[stack_lvl] = box_l; sav_t[stack_lvl] = box_t_;
        sav_r[stack_lvl] = box_r; sav_b[stack_lvl] = box_b;
        stack_lvl++;
        box_l = (dl > box_l) ? dl : box_l;
        box_t_ = (dt > box_t_) ? dt : box_t_;
        box_r = (dr < box_r) ? dr : box_r;
        box_b = (db < box_b) ? db : box_b;
        if (box_r < box_l) box_r = box_l;
        if (box_b < box_t_) box_b = box_t_;
        r.status = tsc_pkg::ST_CLIP_DONE;
        return r;
      end
      tsc_pkg::KIND_POP: begin
        if (stack_lvl == 0) begin
          r.status = tsc_pkg::ST_UNDERFLOW;
          return r;
        end
        stack_lvl--;
        box_l = sav_l[stack_lvl]; box_t_ = sav_t[stack_lvl];
        box_r = sav_r[stack_lvl]; box_b = sav_b[stack_lvl];
        r.status = tsc_pkg::ST_CLIP_DONE;
        return r;
      end
      tsc_pkg::KIND_RESET: begin
        stack_lvl = 0;
        box_l = dl; box_t_ = dt; box_r = dr; box_b = db;
        r.status = tsc_pkg::ST_CLIP_DONE;
        return r;
      end
      default: ;
    endcase
    s_l = c.sl; s_t = c.st; s_r = c.sr; s_b = c.sb;
    if (dl >= dr || dt >= db) begin
      r.status = tsc_pkg::ST_CULL;
      return r;
    end
    dw = dr - dl; dh = db - dt; sw = s_r - s_l; sh = s_b - s_t;
    if (dl < box_l) begin s_l += edge_shift(sw, box_l - dl, dw); dl = box_l; end
    if (dr > box_r) begin s_r += edge_shift(sw, box_r - dr, dw); dr = box_r; end
    if (dt < box_t_) begin s_t += edge_shift(sh, box_t_ - dt, dh); dt = box_t_; end
    if (db > box_b) begin s_b += edge_shift(sh, box_b - db, dh); db = box_b; end
    if (!(dl < dr && dt < db)) begin
      r.status = tsc_pkg::ST_CULL;
      return r;
    end
    s_l = sat32(s_l); s_t = sat32(s_t); s_r = sat32(s_r); s_b = sat32(s_b);
    dw = dr - dl; dh = db - dt;
    if (dw > S32Max) dw = S32Max;
    if (dh > S32Max) dh = S32Max;
    r.status = tsc_pkg::ST_EMIT;
    r.x = dl[31:0]; r.y = dt[31:0];
    r.w = dw[30:0]; r.h = dh[30:0];
    r.sx = s_l[31:0]; r.sy = s_t[31:0];
    r.sw = 32'(sat32(s_r - s_l)); r.sh = 32'(sat32(s_b - s_t));
    r.texture = c.tex; r.tint = c.tint; r.flags = c.flags;
    return r;
  endfunction

  // ---------------- driver: feeds cmd_q onto the in_ stream ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        clip_expect_q.insert(clip_expect_q.size(), clip_predict(cur_cmd));
        items_accepted++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the item until taken
      end else if (cmd_q.size() > 0 &&
                   ((items_accepted >= 700 && items_accepted < 1000) ||
                    $urandom_range(99) >= 10)) begin
        cur_cmd = cmd_q.pop_front();
        in_tdata <= {cur_cmd.flags, cur_cmd.tint, cur_cmd.tex,
                     cur_cmd.sb, cur_cmd.sr, cur_cmd.st, cur_cmd.sl,
                     cur_cmd.rb, cur_cmd.rr, cur_cmd.rt, cur_cmd.rl};
        in_tuser <= cur_cmd.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- monitor: checks results against clip_expect_q ----------------
  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    tsc_pkg::result_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (clip_expect_q.size() == 0) begin
          $error("result item with no command pending");
          mismatches++;
        end else begin
          exp_r = clip_expect_q.pop_front();
          check_field("status", exp_r.status, out_tuser);
          check_field("out_x", exp_r.x, $signed(out_tdata[31:0]));
          check_field("out_y", exp_r.y, $signed(out_tdata[63:32]));
          check_field("out_width", exp_r.w, out_tdata[94:64]);
          check_field("out_height", exp_r.h, out_tdata[125:95]);
          check_field("out_src_x", exp_r.sx, $signed(out_tdata[157:126]));
          check_field("out_src_y", exp_r.sy, $signed(out_tdata[189:158]));
          check_field("out_src_width", exp_r.sw, $signed(out_tdata[221:190]));
          check_field("out_src_height", exp_r.sh, $signed(out_tdata[253:222]));
          check_field("out_texture", exp_r.texture, out_tdata[269:254]);
          check_field("out_tint", exp_r.tint, out_tdata[293:270]);
          check_field("out_flags", exp_r.flags, out_tdata[325:294]);
        end
      end
      // receiver stalls ~10%, never during the no-idle window
      out_tready <= (items_accepted >= 700 && items_accepted < 1000) ||
                    ($urandom_range(99) >= 10);
    end
  end

  // ---------------- watchdog: cycles without any handshake ----------------
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  // mostly a narrow window so boxes and tiles overlap; sometimes full range
  function automatic logic [31:0] rnd_coord();
    if ($urandom_range(9) < 2) return $urandom;
    return 32'(int'($urandom_range(0, 4194304)) - 2097152);
  endfunction

  function automatic tile_cmd_t mk_cmd(tsc_pkg::kind_t k, int l, int t, int r, int b,
                                       int sl = 0, int st = 0, int sr = 0, int sb = 0);
    tile_cmd_t c;
    c.kind = k;
    c.rl = l; c.rt = t; c.rr = r; c.rb = b;
    c.sl = sl; c.st = st; c.sr = sr; c.sb = sb;
    c.tex = $urandom; c.tint = $urandom; c.flags = $urandom;
    return c;
  endfunction

  function automatic void add_cmd(tile_cmd_t c);
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  task automatic add_random(int n);
    tile_cmd_t c;
    int pick;
    logic [31:0] l, t;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      l = rnd_coord(); t = rnd_coord();
      c = mk_cmd(tsc_pkg::KIND_DRAW, l, t,
                 l + ($urandom_range(9) == 0 ? $urandom : $urandom_range(0, 2097152) - 65536),
                 t + ($urandom_range(9) == 0 ? $urandom : $urandom_range(0, 2097152) - 65536),
                 rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      if (pick < 14) c.kind = tsc_pkg::KIND_PUSH;
      else if (pick < 26) c.kind = tsc_pkg::KIND_POP;
      else if (pick < 29) c.kind = tsc_pkg::KIND_RESET;
      add_cmd(c);
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() > 0 || in_tvalid || clip_expect_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    box_l = S32Min; box_t_ = S32Min; box_r = S32Max; box_b = S32Max;
    stack_lvl = 0;
    // directed: underflow, pass-through, empty tiles, full-range extents
    add_cmd(mk_cmd(tsc_pkg::KIND_POP, 0, 0, 0, 0));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, 100, 200, 5000, 6000, 1, 2, 3, 4));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, 5000, 0, 5000, 10, 0, 0, 1, 1));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, 0, 10, 10, -5, 0, 0, 1, 1));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h8000_0000));
    // clip box, then overhang each edge and all edges with extreme sources
    add_cmd(mk_cmd(tsc_pkg::KIND_PUSH, -4096, -4096, 40960, 40960));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, -8192, 0, 4096, 4096, 0, 0, 65536, 65536));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, 0, 0, 81920, 4096, 100, 0, -65536, 65536));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, 0, -9000, 4096, 4096, 0, 7, 65536, -3));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, 0, 0, 4096, 99999, 0, 0, 65536, 123457));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                   32'h7fff_ffff));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, -50000, -50000, -8192, 4096, 0, 0, 9, 9));
    add_cmd(mk_cmd(tsc_pkg::KIND_PUSH, 100000, 100000, 0, 0));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, 0, 0, 40000, 40000, 0, 0, 9, 9));
    add_cmd(mk_cmd(tsc_pkg::KIND_POP, 0, 0, 0, 0));
    add_cmd(mk_cmd(tsc_pkg::KIND_POP, 0, 0, 0, 0));
    // inverted box loaded by reset
    add_cmd(mk_cmd(tsc_pkg::KIND_RESET, 1000, 1000, -1000, -1000));
    add_cmd(mk_cmd(tsc_pkg::KIND_DRAW, -5000, -5000, 5000, 5000, 0, 0, 77, 77));
    // fill the stack past full
    for (int i = 0; i <= StackDepth; i++)
      add_cmd(mk_cmd(tsc_pkg::KIND_PUSH, -i * 4096, -i * 4096, 900000, 900000));
    add_cmd(mk_cmd(tsc_pkg::KIND_RESET, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                   32'h7fff_ffff));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    add_random(850);
    // sender holds off until every expected result is back
    wait_drained();
    add_random(900);
    wait_drained();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && clip_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- tile_scissor_clipper.f -----
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_front.sv
hw/rtl/tsc_divider.sv
hw/rtl/tsc_back.sv
hw/rtl/tile_scissor_clipper.sv
tb/testbench.sv
